FILE: rtl/mps_pkg.sv
`default_nettype none
package mps_pkg;

  localparam int unsigned LIMIT_MAX_DEF   = 1048576;
  localparam int unsigned PRIME_SLOTS_DEF = 82025;

  localparam int unsigned LW = 21;
  localparam int unsigned QW = 21;
  localparam int unsigned MW = 22;
  localparam int unsigned SW = 2;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [SW-1:0] STAT_OK        = 2'd0;
  localparam logic [SW-1:0] STAT_NOT_BUILT = 2'd1;
  localparam logic [SW-1:0] STAT_RANGE     = 2'd2;

  localparam int unsigned REG_SIEVE_LIMIT = 0;

  typedef struct packed {
    logic          op;
    logic [QW-1:0] query_index;
  } mps_in_t;

  typedef struct packed {
    logic signed [MW-1:0] mertens_value;
    logic [SW-1:0]        status;
  } mps_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_RD_I,
    ST_CHK_I,
    ST_RD_P,
    ST_MUL,
    ST_MARK,
    ST_MOD,
    ST_MODCHK,
    ST_NEXT_I,
    ST_PS_RD,
    ST_PS_WR,
    ST_Q_RD,
    ST_Q_DATA,
    ST_DONE
  } mps_state_t;

endpackage
`default_nettype wire

FILE: rtl/mps_ram.sv
`default_nettype none
module mps_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/mobius_prefix_sum_sieve.sv
`default_nettype none
// Mobius prefix-sum sieve. A build request (op 0) runs a linear sieve over
// 1..sieve_limit (0 taken as 1, values above LIMIT_MAX taken as LIMIT_MAX) and
// leaves the Mertens values M(k) in a table with one read and one write port;
// a query request (op 1) returns M(query_index), or status 1 before the first
// build, or status 2 past the built limit. One request is worked at a time. A
// good query reads the table before its result is ready; an error skips the
// read. A build is bound by the memory ports: it clears the tables, then for
// each integer scans the primes (ending early on a divisor) and marks each
// composite with a bit-serial divisibility test over the address width W,
// and ends with a prefix pass. Results wait in an output register.
module mobius_prefix_sum_sieve
  import mps_pkg::*;
#(
  parameter int unsigned LIMIT_MAX   = LIMIT_MAX_DEF,
  parameter int unsigned PRIME_SLOTS = PRIME_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire mps_in_t    in_req,
  output logic            out_valid,
  input  wire logic       out_stall,
  output mps_out_t        out_rsp,
  input  wire logic       cfg_psel,
  input  wire logic       cfg_penable,
  input  wire logic       cfg_pwrite,
  input  wire logic [2:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  localparam int unsigned AW  = $clog2(LIMIT_MAX + 1);
  localparam int unsigned PAW = $clog2(PRIME_SLOTS);
  localparam int unsigned PCW = $clog2(PRIME_SLOTS + 1);
  localparam int unsigned BW  = $clog2(AW);

  mps_state_t state_r, state_nxt;

  logic [LW-1:0]        sieve_limit_r;
  logic [AW-1:0]        n_r, n_nxt;
  logic [AW-1:0]        i_r, i_nxt;
  logic [PCW-1:0]       pc_r, pc_nxt;
  logic [PCW-1:0]       k_r, k_nxt;
  logic signed [MW-1:0] mu_r, mu_nxt;
  logic [AW-1:0]        q_r, q_nxt;
  logic [2*AW-1:0]      prod_r, prod_nxt;
  logic [AW-1:0]        rem_r, rem_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;
  logic signed [MW-1:0] acc_r, acc_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        built_r, built_nxt;
  mps_out_t             res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  mps_out_t             out_rsp_r, out_rsp_nxt;

  logic              mob_we, comp_we, comp_wdata, comp_rdata, pr_we;
  logic [AW-1:0]     mob_waddr, mob_raddr, comp_waddr, comp_raddr;
  logic [MW-1:0]     mob_wdata, mob_rdata;
  logic [PAW-1:0]    pr_waddr, pr_raddr;
  logic [AW-1:0]     pr_wdata, pr_rdata;

  logic              accept, out_free, cfg_wr;
  logic [AW-1:0]     n_clamp;
  logic [AW:0]       rem_sh;
  logic [AW-1:0]     rem_step;
  logic signed [MW-1:0] ps_sum;

  mps_ram #(.W(MW), .D(LIMIT_MAX + 1)) u_mob_ram (
    .clk(clk), .we(mob_we), .waddr(mob_waddr), .wdata(mob_wdata),
    .raddr(mob_raddr), .rdata(mob_rdata)
  );

  mps_ram #(.W(1), .D(LIMIT_MAX + 1)) u_comp_ram (
    .clk(clk), .we(comp_we), .waddr(comp_waddr), .wdata(comp_wdata),
    .raddr(comp_raddr), .rdata(comp_rdata)
  );

  mps_ram #(.W(AW), .D(PRIME_SLOTS)) u_prime_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );

  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(sieve_limit_r);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == 1'(REG_SIEVE_LIMIT));

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (32'(sieve_limit_r) > 32'(LIMIT_MAX)) begin
      n_clamp = AW'(LIMIT_MAX);
    end else if (sieve_limit_r == '0) begin
      n_clamp = AW'(1);
    end else begin
      n_clamp = AW'(sieve_limit_r);
    end
  end

  assign rem_sh   = {rem_r, i_r[bit_r]};
  assign rem_step = (rem_sh >= {1'b0, q_r}) ? AW'(rem_sh - {1'b0, q_r}) : AW'(rem_sh);
  assign ps_sum   = acc_r + $signed(mob_rdata);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req.op == OP_BUILD) begin
            state_nxt = ST_CLR;
          end else if (built_r == '0 || 32'(in_req.query_index) > 32'(built_r)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_Q_RD;
          end
        end
      end
      ST_CLR: begin
        if (i_r == n_r) begin
          state_nxt = (n_r == AW'(1)) ? ST_DONE : ST_RD_I;
        end
      end
      ST_RD_I:   state_nxt = ST_CHK_I;
      ST_CHK_I:  state_nxt = ST_RD_P;
      ST_RD_P:   state_nxt = (k_r == pc_r) ? ST_NEXT_I : ST_MUL;
      ST_MUL:    state_nxt = ST_MARK;
      ST_MARK:   state_nxt = (prod_r > (2*AW)'(n_r)) ? ST_NEXT_I : ST_MOD;
      ST_MOD:    state_nxt = (bit_r == '0) ? ST_MODCHK : ST_MOD;
      ST_MODCHK: state_nxt = (rem_r == '0) ? ST_NEXT_I : ST_RD_P;
      ST_NEXT_I: state_nxt = (i_r == n_r) ? ST_PS_RD : ST_RD_I;
      ST_PS_RD:  state_nxt = ST_PS_WR;
      ST_PS_WR:  state_nxt = (i_r == n_r) ? ST_DONE : ST_PS_RD;
      ST_Q_RD:   state_nxt = ST_Q_DATA;
      ST_Q_DATA: state_nxt = ST_DONE;
      ST_DONE:   state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    n_nxt = n_r; i_nxt = i_r; pc_nxt = pc_r; k_nxt = k_r; mu_nxt = mu_r;
    q_nxt = q_r; prod_nxt = prod_r; rem_nxt = rem_r; bit_nxt = bit_r;
    acc_nxt = acc_r; idx_nxt = idx_r; built_nxt = built_r; res_nxt = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    mob_we = 1'b0; mob_waddr = i_r; mob_wdata = '0; mob_raddr = i_r;
    comp_we = 1'b0; comp_waddr = i_r; comp_wdata = 1'b0; comp_raddr = i_r;
    pr_we = 1'b0; pr_waddr = pc_r[PAW-1:0]; pr_wdata = i_r; pr_raddr = k_r[PAW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt.mertens_value = '0;
          res_nxt.status        = STAT_OK;
          n_nxt   = n_clamp;
          i_nxt   = '0;
          pc_nxt  = (in_req.op == OP_BUILD) ? '0 : pc_r;
          idx_nxt = AW'(in_req.query_index);
          if (in_req.op == OP_QUERY) begin
            if (built_r == '0) begin
              res_nxt.status = STAT_NOT_BUILT;
            end else if (32'(in_req.query_index) > 32'(built_r)) begin
              res_nxt.status = STAT_RANGE;
            end
          end
        end
      end
      ST_CLR: begin
        mob_we     = 1'b1;
        mob_wdata  = (i_r == AW'(1)) ? MW'(1) : '0;
        comp_we    = 1'b1;
        i_nxt      = (i_r == n_r) ? AW'(2) : i_r + AW'(1);
        if (i_r == n_r && n_r == AW'(1)) begin
          built_nxt = n_r;
        end
      end
      ST_RD_I: begin
      end
      ST_CHK_I: begin
        k_nxt = '0;
        if (!comp_rdata) begin
          mu_nxt    = -MW'(1);
          mob_we    = 1'b1;
          mob_wdata = -MW'(1);
          if (pc_r < PCW'(PRIME_SLOTS)) begin
            pr_we  = 1'b1;
            pc_nxt = pc_r + PCW'(1);
          end
        end else begin
          mu_nxt = $signed(mob_rdata);
        end
      end
      ST_RD_P: begin
      end
      ST_MUL: begin
        q_nxt    = pr_rdata;
        prod_nxt = i_r * pr_rdata;
      end
      ST_MARK: begin
        rem_nxt = '0;
        bit_nxt = BW'(AW - 1);
        if (prod_r <= (2*AW)'(n_r)) begin
          mob_we     = 1'b1;
          mob_waddr  = prod_r[AW-1:0];
          mob_wdata  = -mu_r;
          comp_we    = 1'b1;
          comp_waddr = prod_r[AW-1:0];
          comp_wdata = 1'b1;
        end
      end
      ST_MOD: begin
        rem_nxt = rem_step;
        bit_nxt = bit_r - BW'(1);
      end
      ST_MODCHK: begin
        if (rem_r == '0) begin
          mob_we    = 1'b1;
          mob_waddr = prod_r[AW-1:0];
          mob_wdata = '0;
        end else begin
          k_nxt = k_r + PCW'(1);
        end
      end
      ST_NEXT_I: begin
        if (i_r == n_r) begin
          i_nxt   = AW'(2);
          acc_nxt = MW'(1);
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      ST_PS_RD: begin
      end
      ST_PS_WR: begin
        mob_we    = 1'b1;
        mob_wdata = ps_sum;
        acc_nxt   = ps_sum;
        i_nxt     = i_r + AW'(1);
        if (i_r == n_r) begin
          built_nxt = n_r;
        end
      end
      ST_Q_RD: begin
        mob_raddr = idx_r;
      end
      ST_Q_DATA: begin
        res_nxt.mertens_value = $signed(mob_rdata);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pc_r          <= '0;
      built_r       <= '0;
      out_valid_r   <= 1'b0;
      sieve_limit_r <= LW'(LIMIT_MAX);
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        sieve_limit_r <= cfg_pwdata[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    mu_r      <= mu_nxt;
    q_r       <= q_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    bit_r     <= bit_nxt;
    acc_r     <= acc_nxt;
    idx_r     <= idx_nxt;
    res_r     <= res_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

`ifndef SYNTH
  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PCW'(PRIME_SLOTS))
    else $error("prime count past slots");

  a_i_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHK_I |-> (i_r >= AW'(2) && i_r <= n_r))
    else $error("sieve index out of range");

  a_not_built: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req.op == OP_QUERY && built_r == '0
    |=> state_r == ST_DONE && res_r.status == STAT_NOT_BUILT)
    else $error("query before build not rejected");

  a_built_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(built_r) <= 32'(LIMIT_MAX))
    else $error("built limit too large");
`endif

endmodule
`default_nettype wire
